/* rtl/core/glpf_pkg.sv */
// Shared constants and codes for the grid local peak finder.
`timescale 1ns / 1ps

package glpf_pkg;

   // Default sizes handed to the top level as parameter defaults.
   localparam int DEF_MAX_COLS    = 1024;
   localparam int DEF_MAX_ROWS    = 1024;
   localparam int DEF_HEIGHT_BITS = 32;

   // Fixed field widths.
   localparam int CFG_W     = 11;
   localparam int OUT_W     = 10;
   localparam int CSR_IDX_W = 1;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS = 1'b0,
      CSR_GRID_COLS = 1'b1
   } csr_index_type;

   // Input word command codes.
   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

endpackage

/* rtl/core/glpf_ram.sv */
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module glpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* rtl/core/grid_local_peak_finder.sv */
// Top level of the four-neighbour local peak finder over a raster-ordered grid.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_cmd, req_height
// rsp       out        rsp_valid / rsp_ready   rsp_peak_row, rsp_peak_col
// csr       in         csr_wr_en (no wait)     csr_index, csr_wr_data
//
// One input word is taken every cycle while the result side keeps up. A word
// is registered into the decision stage, where the line buffer read data
// meets the four neighbour compares; a peak is registered into the result
// register as its deciding word leaves that stage. The single write port of
// the line buffer and the two read ports set that rate. Reset is synchronous
// and clears the counters, the pipeline valid flags and both size registers
// (to one); the line buffer is not cleared. A stalled result stalls only a
// word that is itself a peak.

module grid_local_peak_finder
   import glpf_pkg::*;
#(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic signed [HEIGHT_BITS-1:0] req_height,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [OUT_W-1:0]              rsp_peak_row,
   output logic [OUT_W-1:0]              rsp_peak_col,

   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CFG_W-1:0]              csr_wr_data
);

   localparam int HB   = HEIGHT_BITS;
   localparam int AW   = $clog2(MAX_COLS);
   localparam int CW   = $clog2(MAX_COLS + 1);
   localparam int RCW  = $clog2(MAX_ROWS + 1);
   localparam int RW   = RCW + 1;
   localparam int CMW  = (CW > CFG_W) ? CW : CFG_W;
   localparam int RMW  = (RCW > CFG_W) ? RCW : CFG_W;
   localparam int CXW  = (AW > OUT_W) ? AW : OUT_W;
   localparam int RXW  = (RW > OUT_W) ? RW : OUT_W;

   // Size registers.
   logic [CFG_W-1:0] grid_rows_ff, grid_rows_in;
   logic [CFG_W-1:0] grid_cols_ff, grid_cols_in;

   // Position counters: next column, and row of the next pixel.
   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // Decision stage.
   logic                 s1_valid_ff, s1_valid_in;
   logic [AW-1:0]        s1_c_ff;
   logic [RW-1:0]        s1_d_ff;
   logic                 s1_eval_ff;
   logic                 s1_left_ff;
   logic                 s1_right_ff;
   logic                 s1_up_ff;
   logic                 s1_drain_ff;
   logic signed [HB-1:0] s1_h_ff;
   logic                 s1_fwd_a_ff;
   logic                 s1_fwd_b_ff;
   logic [2*HB-1:0]      s1_fwd_data_ff;
   logic signed [HB-1:0] left_hold_ff;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_row_ff;
   logic [OUT_W-1:0] rsp_col_ff;

   // Size decoding: zero acts as one, oversize acts as the maximum.
   logic [CMW-1:0] cols_wide;
   logic [RMW-1:0] rows_wide;
   logic [CW-1:0]  cols_eff;
   logic [RCW-1:0] rows_eff;

   always_comb begin
      cols_wide = CMW'(grid_cols_ff);
      rows_wide = RMW'(grid_rows_ff);
      if (cols_wide == '0) begin
         cols_eff = CW'(1);
      end else if (cols_wide > CMW'(MAX_COLS)) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(cols_wide);
      end
      if (rows_wide == '0) begin
         rows_eff = RCW'(1);
      end else if (rows_wide > RMW'(MAX_ROWS)) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = RCW'(rows_wide);
      end
   end

   // Input side: work out the cell position of the word on offer.
   logic          wrap_pre;
   logic [AW-1:0] c0;
   logic [RW-1:0] row_pre;
   logic [CW-1:0] c_next;
   logic          end_row;
   logic          drain0;
   logic          ignore;
   logic          accept;
   logic          load;
   logic          s1_fire;

   always_comb begin
      // A column count narrowed below the current column ends the row at once.
      wrap_pre = CW'(col_ff) >= cols_eff;
      c0       = wrap_pre ? '0 : col_ff;
      row_pre  = wrap_pre ? row_ff + 1'b1 : row_ff;
      c_next   = CW'(c0) + 1'b1;
      end_row  = c_next >= cols_eff;
      drain0   = req_cmd == CMD_DRAIN;
      // A drain before any row, or a pixel past the full grid, is dropped.
      ignore   = drain0 ? (row_pre == '0) : (row_pre >= RW'(rows_eff));
   end

   assign req_ready = !s1_valid_ff || s1_fire;
   assign accept    = req_valid && req_ready;
   assign load      = accept && !ignore;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (ignore) begin
            col_in = c0;
            row_in = row_pre;
         end else if (end_row) begin
            // A drain that passes the last column closes the frame.
            col_in = '0;
            row_in = drain0 ? '0 : row_pre + 1'b1;
         end else begin
            col_in = c_next[AW-1:0];
            row_in = row_pre;
         end
      end
   end

   // Line buffer: each entry holds {row above, row being decided}.
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [2*HB-1:0] wr_data;
   logic [AW-1:0]   rd_addr_b;
   logic [2*HB-1:0] rd_data_a;
   logic [2*HB-1:0] rd_data_b;

   assign rd_addr_b = c_next[AW-1:0];

   glpf_ram #(
      .WIDTH (2 * HB),
      .DEPTH (MAX_COLS)
   ) u_line_buf (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (load),
      .rd_addr_a (c0),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Decision stage. The word ahead writes the buffer in the same cycle as
   // this word's read, so a matching address takes the write data instead.
   logic signed [HB-1:0] center;
   logic signed [HB-1:0] upper;
   logic signed [HB-1:0] right;
   logic                 peak;

   always_comb begin
      center = s1_fwd_a_ff ? s1_fwd_data_ff[HB-1:0]    : rd_data_a[HB-1:0];
      upper  = s1_fwd_a_ff ? s1_fwd_data_ff[2*HB-1:HB] : rd_data_a[2*HB-1:HB];
      right  = s1_fwd_b_ff ? s1_fwd_data_ff[HB-1:0]    : rd_data_b[HB-1:0];
      peak   = s1_eval_ff
               && !(s1_left_ff && (center < left_hold_ff))
               && !(s1_right_ff && (center < right))
               && !(s1_up_ff && (center < upper))
               && !(!s1_drain_ff && (center < s1_h_ff));
   end

   assign s1_fire = s1_valid_ff && (!peak || !rsp_valid_ff || rsp_ready);
   assign wr_en   = s1_fire && !s1_drain_ff;
   assign wr_addr = s1_c_ff;
   assign wr_data = {center, s1_h_ff};

   assign s1_valid_in  = load ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_fire && peak) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Size register writes.
   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_ROWS: grid_rows_in = csr_wr_data;
            CSR_GRID_COLS: grid_cols_in = csr_wr_data;
            default: begin
               grid_rows_in = grid_rows_ff;
               grid_cols_in = grid_cols_ff;
            end
         endcase
      end
   end

   // Output indices are kept to their low ten bits.
   logic [CXW-1:0] col_ext;
   logic [RXW-1:0] row_ext;

   assign col_ext = CXW'(s1_c_ff);
   assign row_ext = RXW'(s1_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= CFG_W'(1);
         grid_cols_ff <= CFG_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_hold_ff <= '0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            left_hold_ff <= center;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_c_ff        <= c0;
         s1_d_ff        <= row_pre - 1'b1;
         s1_eval_ff     <= row_pre != '0;
         s1_left_ff     <= c0 != '0;
         s1_right_ff    <= !end_row;
         s1_up_ff       <= row_pre > RW'(1);
         s1_drain_ff    <= drain0;
         s1_h_ff        <= req_height;
         s1_fwd_a_ff    <= wr_en && (wr_addr == c0);
         s1_fwd_b_ff    <= wr_en && (wr_addr == rd_addr_b);
         s1_fwd_data_ff <= wr_data;
      end
      if (s1_fire && peak) begin
         rsp_row_ff <= row_ext[OUT_W-1:0];
         rsp_col_ff <= col_ext[OUT_W-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_peak_row = rsp_row_ff;
   assign rsp_peak_col = rsp_col_ff;

endmodule

/* tb/grid_local_peak_finder_test.sv */
// Self-checking testbench for the four-neighbour grid local peak finder.
`timescale 1ns / 1ps

// The bench streams grids of signed heights into the block in raster order and
// follows every accepted word with its own model of the two line buffers, the
// left neighbour and the row and column counters. Each peak the model decides
// is queued with its row and column. The checker compares every result word
// against the oldest queued peak, field by field.
//
// The size registers are only written while the block is idle. Column widening
// only happens at a frame boundary. Inside a frame every line buffer entry the
// block reads was therefore filled earlier in the same frame.

module grid_local_peak_finder_test;
   import glpf_pkg::*;

   localparam int HB           = DEF_HEIGHT_BITS;
   localparam int MAXC         = DEF_MAX_COLS;
   localparam int MAXR         = DEF_MAX_ROWS;
   localparam int SETTLE       = 4;       // margin after the last peak for any extra result word
   localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles
   localparam int RANDOM_WORDS = 2000;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic signed [HB-1:0] H_MIN = {1'b1, {(HB-1){1'b0}}};
   localparam logic signed [HB-1:0] H_MAX = {1'b0, {(HB-1){1'b1}}};

   typedef struct packed {
      logic [OUT_W-1:0] row;
      logic [OUT_W-1:0] col;
   } peak_pos_type;

   // How the heights of one frame are drawn.
   typedef enum int {
      HT_WIDE,
      HT_TIES,
      HT_EXTREME
   } height_mix_type;

   // Shapes of a random frame.
   typedef enum int {
      FRAME_FULL,
      FRAME_EARLY,
      FRAME_OVERFULL,
      FRAME_STRAY,
      FRAME_NARROW
   } frame_shape_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_cmd;
   logic signed [HB-1:0]   req_height;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [OUT_W-1:0]       rsp_peak_row;
   logic [OUT_W-1:0]       rsp_peak_col;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CFG_W-1:0]       csr_wr_data;

   // Model of the block: line buffers, left neighbour, counters and size registers.
   logic signed [HB-1:0]   row_above [MAXC];
   logic signed [HB-1:0]   row_mid [MAXC];
   logic signed [HB-1:0]   left_height = '0;
   int unsigned            next_row = 0;
   int unsigned            next_col = 0;
   logic [CFG_W-1:0]       rows_reg = CFG_W'(1);
   logic [CFG_W-1:0]       cols_reg = CFG_W'(1);

   peak_pos_type           peaks_due[$];
   peak_pos_type           peak_head;

   bit                     steady = 1'b0;     // no random idling on either side
   int                     holds_asked = 0;
   int                     holds_done = 0;
   int                     stall_left = 0;
   int                     failures = 0;
   int                     peaks_checked = 0;
   int                     words_used = 0;
   int                     words_ignored = 0;
   int                     frames_done = 0;
   int                     cycle_count = 0;
   int                     waited;

   grid_local_peak_finder i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_height   (req_height),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_peak_row (rsp_peak_row),
      .rsp_peak_col (rsp_peak_col),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The run is abandoned once the total cycle count reaches its limit.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d peaks still due", $time, peaks_due.size());
         $display("grid_local_peak_finder: mismatch");
         $finish;
      end
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 2);
      if (pick < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 80);
   endfunction

   function automatic int unsigned rows_in_use();
      if (rows_reg == 0) return 1;
      return (rows_reg > MAXR) ? MAXR : rows_reg;
   endfunction

   function automatic int unsigned cols_in_use();
      if (cols_reg == 0) return 1;
      return (cols_reg > MAXC) ? MAXC : cols_reg;
   endfunction

   function automatic logic signed [HB-1:0] pick_height(input height_mix_type mix);
      case (mix)
         HT_TIES: begin
            return HB'(int'($urandom_range(0, 4)) - 2);
         end
         HT_EXTREME: begin
            case ($urandom_range(0, 3))
               0: return H_MIN;
               1: return H_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: begin
            return HB'($urandom);
         end
      endcase
   endfunction

   // Decide the cell above the incoming word, as the block does, and queue a
   // peak when the cell is at least as high as all its existing neighbours.
   function automatic void decide_cell(input logic cmd, input logic signed [HB-1:0] h);
      int unsigned          rows;
      int unsigned          cols;
      int unsigned          c;
      logic signed [HB-1:0] centre;
      bit                   peak;
      peak_pos_type         pos;
      rows = rows_in_use();
      cols = cols_in_use();
      // A narrowed column count ends the current row before anything else.
      if (next_col >= cols) begin
         next_col = 0;
         next_row = next_row + 1;
      end
      c = next_col;
      // A drain with no row received yet, or a pixel past the full grid, is ignored.
      if ((cmd == CMD_DRAIN) ? (next_row == 0) : (next_row >= rows)) begin
         words_ignored = words_ignored + 1;
         return;
      end
      words_used = words_used + 1;
      centre = row_mid[c];
      if (next_row >= 1) begin
         peak = 1'b1;
         if (c > 0 && centre < left_height) peak = 1'b0;
         if (c + 1 < cols && centre < row_mid[c + 1]) peak = 1'b0;
         if (next_row > 1 && centre < row_above[c]) peak = 1'b0;
         if (cmd == CMD_PIXEL && centre < h) peak = 1'b0;
         if (peak) begin
            pos.row = OUT_W'(next_row - 1);
            pos.col = OUT_W'(c);
            peaks_due.push_back(pos);
         end
      end
      left_height = centre;
      if (cmd == CMD_PIXEL) begin
         row_above[c] = centre;
         row_mid[c]   = h;
      end
      next_col = c + 1;
      if (next_col >= cols) begin
         next_col = 0;
         // Drains close the frame; pixels move on to the next row.
         next_row = (cmd == CMD_DRAIN) ? 0 : next_row + 1;
      end
   endfunction

   // Offer one word after a random gap and hold it until it is taken.
   task automatic send_word(input logic cmd, input logic signed [HB-1:0] h);
      int gap;
      gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_height <= h;
      do @(posedge clock); while (!req_ready);
      decide_cell(cmd, h);
   endtask

   // Stop sending and let every queued peak arrive, plus the pipeline depth,
   // since the last word may have been one that makes no result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (peaks_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_size(input csr_index_type idx, input logic [CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      if (idx == CSR_GRID_ROWS) begin
         rows_reg = value;
      end else begin
         cols_reg = value;
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
      wait_idle();
      write_size(CSR_GRID_ROWS, rows_val);
      write_size(CSR_GRID_COLS, cols_val);
   endtask

   // Bring the counters back to the start of a frame. Row zero is completed
   // with pixels, since drains are ignored there; after that, drains close it.
   task automatic finish_frame(input height_mix_type mix);
      while (next_row != 0 || next_col != 0) begin
         if (next_row == 0) begin
            send_word(CMD_PIXEL, pick_height(mix));
         end else begin
            send_word(CMD_DRAIN, pick_height(mix));
         end
      end
   endtask

   // Result side: random stalls, and a long hold-off whenever a test asks for one.
   always @(posedge clock) begin
      if (holds_asked != holds_done) begin
         holds_done = holds_asked;
         stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!steady && $urandom_range(0, 99) < 30) stall_left = idle_cycles();
      end
   end

   // Every result word must match the oldest peak still due.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (peaks_due.size() == 0) begin
            $display("%0t: unexpected peak at row %0d col %0d, none was due",
                     $time, rsp_peak_row, rsp_peak_col);
            failures = failures + 1;
         end else begin
            peak_head = peaks_due.pop_front();
            peaks_checked = peaks_checked + 1;
            if (rsp_peak_row !== peak_head.row) begin
               $display("%0t: peak row expected %0d, got %0d",
                        $time, peak_head.row, rsp_peak_row);
               failures = failures + 1;
            end
            if (rsp_peak_col !== peak_head.col) begin
               $display("%0t: peak col expected %0d, got %0d",
                        $time, peak_head.col, rsp_peak_col);
               failures = failures + 1;
            end
         end
      end
   end

   // Sizes straight out of reset are one by one. A drain before any row is
   // ignored, so is a second pixel once the single-cell grid is full, and the
   // closing drain reports the lone cell as a peak.
   task automatic test_ignored_words();
      send_word(CMD_DRAIN, $urandom);
      send_word(CMD_PIXEL, -5);
      send_word(CMD_PIXEL, 17);
      send_word(CMD_DRAIN, '0);
      finish_frame(HT_WIDE);
   endtask

   // A small grid built from the most negative and most positive heights,
   // zero, minus one and plateaus, so that every height bit takes both values.
   task automatic test_extreme_heights();
      logic signed [HB-1:0] cells [12];
      cells = '{H_MIN, H_MAX, '0, '1,
                H_MAX, H_MAX, '1, H_MIN,
                '0,    5,     5,  H_MAX};
      set_grid(CFG_W'(3), CFG_W'(4));
      foreach (cells[i]) send_word(CMD_PIXEL, cells[i]);
      finish_frame(HT_EXTREME);
   endtask

   // A rows value beyond the maximum, an early drain, and a column count
   // narrowed to zero (acting as one) while the current row is partly done.
   task automatic test_narrow_mid_row();
      set_grid({CFG_W{1'b1}}, CFG_W'(3));
      repeat (7) send_word(CMD_PIXEL, pick_height(HT_TIES));
      wait_idle();
      write_size(CSR_GRID_COLS, '0);
      send_word(CMD_DRAIN, pick_height(HT_WIDE));
      finish_frame(HT_TIES);
   endtask

   // The widest row, with an all-ones columns value that acts as the maximum.
   task automatic test_widest_row();
      set_grid(CFG_W'(1), {CFG_W{1'b1}});
      repeat (MAXC) send_word(CMD_PIXEL, pick_height(HT_TIES));
      finish_frame(HT_TIES);
   endtask

   // The tallest column, so that peak rows reach the top of their range.
   task automatic test_tallest_column();
      set_grid(CFG_W'(MAXR), CFG_W'(1));
      repeat (MAXR) send_word(CMD_PIXEL, pick_height(HT_TIES));
      finish_frame(HT_TIES);
   endtask

   // A flat grid makes every cell a peak. The receiver holds off for a long
   // stretch while the sender keeps offering words, so the block fills up and
   // stalls its input; afterwards the sender waits for every peak to arrive.
   task automatic test_result_stall();
      set_grid(CFG_W'(4), CFG_W'(16));
      steady = 1'b1;
      holds_asked = holds_asked + 1;
      repeat (64) send_word(CMD_PIXEL, 7);
      finish_frame(HT_TIES);
      steady = 1'b0;
      wait_idle();
   endtask

   // One random frame: mostly well-formed, with random content, and now and
   // then early drains, surplus pixels, stray drains or a mid-row narrowing.
   task automatic random_frame();
      height_mix_type   mix;
      frame_shape_type  shape;
      int unsigned      nr;
      int unsigned      nc;
      int               pick;
      int               full_rows;
      int               part;
      logic [CFG_W-1:0] rows_val;
      logic [CFG_W-1:0] cols_val;
      mix = height_mix_type'($urandom_range(0, 2));
      steady = ($urandom_range(0, 9) == 0);
      if (frames_done == 0 || $urandom_range(0, 9) < 7) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)      rows_val = CFG_W'($urandom_range(1, 6));
         else if (pick < 85) rows_val = '0;
         else if (pick < 90) rows_val = CFG_W'($urandom_range(MAXR + 1, (1 << CFG_W) - 1));
         else                rows_val = CFG_W'($urandom_range(7, 40));
         pick = $urandom_range(0, 99);
         if (pick < 80)      cols_val = CFG_W'($urandom_range(1, 8));
         else if (pick < 85) cols_val = '0;
         else                cols_val = CFG_W'($urandom_range(9, 64));
         set_grid(rows_val, cols_val);
      end
      nr = rows_in_use();
      nc = cols_in_use();
      pick = $urandom_range(0, 99);
      if (pick < 70)      shape = FRAME_FULL;
      else if (pick < 82) shape = FRAME_EARLY;
      else if (pick < 88) shape = FRAME_OVERFULL;
      else if (pick < 94) shape = FRAME_STRAY;
      else                shape = FRAME_NARROW;
      // Tall grids are cut short by drains to keep the run brief.
      if (nr > 12 && shape != FRAME_NARROW) shape = FRAME_EARLY;
      if (nr < 2 && shape == FRAME_EARLY) shape = FRAME_FULL;
      if (nc < 2 && shape == FRAME_NARROW) shape = FRAME_FULL;

      if (shape == FRAME_STRAY) begin
         repeat ($urandom_range(1, 2)) send_word(CMD_DRAIN, $urandom);
      end
      full_rows = nr;
      if (shape == FRAME_EARLY)  full_rows = $urandom_range(1, (nr - 1 < 4) ? nr - 1 : 4);
      if (shape == FRAME_NARROW) full_rows = $urandom_range(0, (nr - 1 < 3) ? nr - 1 : 3);
      repeat (full_rows * nc) send_word(CMD_PIXEL, pick_height(mix));

      case (shape)
         FRAME_EARLY: begin
            repeat ($urandom_range(0, nc - 1)) send_word(CMD_PIXEL, pick_height(mix));
         end
         FRAME_OVERFULL: begin
            repeat ($urandom_range(1, 3)) send_word(CMD_PIXEL, pick_height(mix));
         end
         FRAME_NARROW: begin
            part = $urandom_range(1, nc - 1);
            repeat (part) send_word(CMD_PIXEL, pick_height(mix));
            wait_idle();
            write_size(CSR_GRID_COLS, CFG_W'($urandom_range(0, part)));
         end
         default: begin
         end
      endcase
      finish_frame(mix);
      frames_done = frames_done + 1;
   endtask

   task automatic test_random_frames();
      int start;
      start = words_used;
      while (words_used < start + RANDOM_WORDS) random_frame();
      steady = 1'b0;
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_cmd     <= CMD_PIXEL;
      req_height  <= '0;
      rsp_ready   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_GRID_ROWS;
      csr_wr_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_ignored_words();
      test_extreme_heights();
      test_narrow_mid_row();
      test_widest_row();
      test_tallest_column();
      test_result_stall();
      test_random_frames();

      // Let the last peaks out, then give the pipeline time to show any extra word.
      req_valid <= 1'b0;
      waited = 0;
      while (peaks_due.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited = waited + 1;
      end
      repeat (SETTLE) @(posedge clock);
      if (peaks_due.size() != 0) begin
         $display("%0t: %0d peaks never arrived, next due at row %0d col %0d",
                  $time, peaks_due.size(), peaks_due[0].row, peaks_due[0].col);
         failures = failures + peaks_due.size();
      end

      $display("Run covered %0d frames: %0d words decided cells and %0d were ignored.",
               frames_done, words_used, words_ignored);
      $display("Grids ran up to %0d rows and %0d columns; %0d peaks were checked, %0d errors.",
               MAXR, MAXC, peaks_checked, failures);
      if (failures == 0) begin
         $display("grid_local_peak_finder: match");
      end else begin
         $display("grid_local_peak_finder: mismatch");
      end
      $finish;
   end

endmodule
